// ===== hw/rtl/wsbc_pkg.sv =====
// Shared types, constants and the control program for the word stream bit chunker.
package wsbc_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 5;
    localparam int STEP_W = 3;

    localparam logic [CFG_W-1:0] CHUNK_WIDTH_RST = CFG_W'(8);

    // Register indexes on the configuration port
    localparam logic REG_CHUNK_WIDTH = 1'b0;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT      = 3'd0;
    localparam step_t STEP_DISPATCH  = 3'd1;
    localparam step_t STEP_RUN_CHECK = 3'd2;
    localparam step_t STEP_RUN_EMIT  = 3'd3;
    localparam step_t STEP_FIN_CHECK = 3'd4;
    localparam step_t STEP_FIN_EMIT  = 3'd5;
    localparam step_t STEP_FIN_CLEAR = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_FINAL,
        COND_FULL,
        COND_MORE_FULL,
        COND_ACC_NZ,
        COND_MORE_NZ
    } cond_t;

    // One microcode word
    typedef struct packed {
        logic  take;
        logic  emit;
        logic  emit_final;
        logic  clear;
        cond_t cond;
        step_t jump_true;
        step_t jump_false;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic emit_final;
        logic clear;
    } wsbc_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic final_word;
        logic full;
        logic more_full;
        logic acc_nz;
        logic more_nz;
        logic out_free;
    } wsbc_stat_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{take: 1'b0, emit: 1'b0, emit_final: 1'b0, clear: 1'b0,
              cond: COND_ALWAYS, jump_true: STEP_WAIT, jump_false: STEP_WAIT};
        case (step)
            STEP_WAIT:
            begin
                w.take       = 1'b1;
                w.cond       = COND_IN_VALID;
                w.jump_true  = STEP_DISPATCH;
                w.jump_false = STEP_WAIT;
            end
            STEP_DISPATCH:
            begin
                w.cond       = COND_FINAL;
                w.jump_true  = STEP_FIN_CHECK;
                w.jump_false = STEP_RUN_CHECK;
            end
            STEP_RUN_CHECK:
            begin
                w.cond       = COND_FULL;
                w.jump_true  = STEP_RUN_EMIT;
                w.jump_false = STEP_WAIT;
            end
            STEP_RUN_EMIT:
            begin
                w.emit       = 1'b1;
                w.cond       = COND_MORE_FULL;
                w.jump_true  = STEP_RUN_EMIT;
                w.jump_false = STEP_WAIT;
            end
            STEP_FIN_CHECK:
            begin
                w.cond       = COND_ACC_NZ;
                w.jump_true  = STEP_FIN_EMIT;
                w.jump_false = STEP_FIN_CLEAR;
            end
            STEP_FIN_EMIT:
            begin
                w.emit       = 1'b1;
                w.emit_final = 1'b1;
                w.cond       = COND_MORE_NZ;
                w.jump_true  = STEP_FIN_EMIT;
                w.jump_false = STEP_FIN_CLEAR;
            end
            STEP_FIN_CLEAR:
            begin
                w.clear      = 1'b1;
                w.cond       = COND_ALWAYS;
                w.jump_true  = STEP_WAIT;
                w.jump_false = STEP_WAIT;
            end
            default:
            begin
                w.cond       = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/wsbc_sequencer.sv =====
// Microcode sequencer: step counter, control ROM and condition/jump logic.
module wsbc_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  wsbc_pkg::wsbc_stat_t stat,
    output logic                 in_stall,
    output wsbc_pkg::wsbc_ctrl_t ctrl
);
    import wsbc_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t uw;
    logic   cond_hit;
    logic   hold;

    assign uw = ucode_rom(pc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_IN_VALID:  cond_hit = in_valid;
            COND_FINAL:     cond_hit = stat.final_word;
            COND_FULL:      cond_hit = stat.full;
            COND_MORE_FULL: cond_hit = stat.more_full;
            COND_ACC_NZ:    cond_hit = stat.acc_nz;
            COND_MORE_NZ:   cond_hit = stat.more_nz;
            default:        cond_hit = 1'b0;
        endcase
    end

    // an emit step waits in place until the output register can take a chunk
    assign hold = uw.emit && !stat.out_free;

    assign in_stall        = !uw.take;
    assign ctrl.load       = uw.take && in_valid;
    assign ctrl.emit       = uw.emit && stat.out_free;
    assign ctrl.emit_final = uw.emit_final;
    assign ctrl.clear      = uw.clear;

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit)
        begin
            pc_next = uw.jump_true;
        end
        else
        begin
            pc_next = uw.jump_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/wsbc_datapath.sv =====
// Datapath: bit accumulator, fill count, chunk shifter and output register.
module wsbc_datapath #(
    parameter int MAX_CHUNK_WIDTH = 31
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [wsbc_pkg::CFG_W-1:0] chunk_width,
    input  logic                       cfg_clear,
    input  logic [wsbc_pkg::WORD_W-1:0] data_word,
    input  logic                       final_word,
    input  wsbc_pkg::wsbc_ctrl_t       ctrl,
    output wsbc_pkg::wsbc_stat_t       stat,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [MAX_CHUNK_WIDTH-1:0] chunk_value,
    output logic                       run_end,
    output logic                       string_end
);
    import wsbc_pkg::*;

    // residue is at most MAX_CHUNK_WIDTH-1 bits, plus one word
    localparam int ACC_W = MAX_CHUNK_WIDTH - 1 + WORD_W;
    localparam int LEN_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           len_next;
    logic                       final_reg;
    logic                       final_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [MAX_CHUNK_WIDTH-1:0] chunk_reg;
    logic [MAX_CHUNK_WIDTH-1:0] chunk_next;
    logic                       run_end_reg;
    logic                       run_end_next;
    logic                       string_end_reg;
    logic                       string_end_next;

    logic [CFG_W-1:0]           w_eff;
    logic [LEN_W-1:0]           w_len;
    logic [LEN_W-1:0]           len_rem;
    logic [ACC_W-1:0]           acc_shift;
    logic [MAX_CHUNK_WIDTH-1:0] chunk_mask;
    logic                       full;
    logic                       more_full;
    logic                       more_nz;

    // zero reads as one, oversize clamps to the max
    always_comb
    begin
        if (chunk_width == '0)
        begin
            w_eff = CFG_W'(1);
        end
        else if (chunk_width > CFG_W'(MAX_CHUNK_WIDTH))
        begin
            w_eff = CFG_W'(MAX_CHUNK_WIDTH);
        end
        else
        begin
            w_eff = chunk_width;
        end
    end

    assign w_len      = LEN_W'(w_eff);
    assign len_rem    = len_reg - w_len;
    assign full       = (len_reg >= w_len);
    assign more_full  = full && (len_rem >= w_len);
    assign acc_shift  = acc_reg >> w_eff;
    assign more_nz    = |acc_shift;
    assign chunk_mask = ~({MAX_CHUNK_WIDTH{1'b1}} << w_eff);

    assign stat.final_word = final_reg;
    assign stat.full       = full;
    assign stat.more_full  = more_full;
    assign stat.acc_nz     = |acc_reg;
    assign stat.more_nz    = more_nz;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        acc_next   = acc_reg;
        len_next   = len_reg;
        final_next = final_reg;
        if (cfg_clear || ctrl.clear)
        begin
            acc_next = '0;
            len_next = '0;
        end
        else if (ctrl.load)
        begin
            acc_next   = acc_reg | (ACC_W'(data_word) << len_reg);
            len_next   = len_reg + LEN_W'(WORD_W);
            final_next = final_word;
        end
        else if (ctrl.emit)
        begin
            acc_next = acc_shift;
            len_next = len_rem;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        chunk_next      = chunk_reg;
        run_end_next    = run_end_reg;
        string_end_next = string_end_reg;
        if (ctrl.emit)
        begin
            out_valid_next  = 1'b1;
            chunk_next      = acc_reg[MAX_CHUNK_WIDTH-1:0] & chunk_mask;
            run_end_next    = ctrl.emit_final ? !more_nz : !more_full;
            string_end_next = ctrl.emit_final && !more_nz;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            len_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            len_reg       <= len_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_reg      <= chunk_next;
        run_end_reg    <= run_end_next;
        string_end_reg <= string_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign chunk_value = chunk_reg;
    assign run_end     = run_end_reg;
    assign string_end  = string_end_reg;

endmodule

// ===== hw/rtl/word_stream_bit_chunker_unit.sv =====
// Top level of the word stream bit chunker: config register and the sequencer/datapath pair.
//
// Cuts a bit string, delivered as 32-bit words least significant first, into
// chunks of chunk_width bits (1 to MAX_CHUNK_WIDTH; 0 reads as 1, larger values
// clamp), emitted least significant first with run_end on the last chunk of each
// word. Leftover bits carry into the next word. On the word marked final_word the
// string is cut at its highest set bit, so the top chunk may be short, and
// string_end marks it; an all-zero tail gives no chunk at all. A small microcoded
// sequencer steps a shift datapath and produces one chunk per cycle while the
// output is not stalled. A word that is not final passes through the wait,
// dispatch and check steps and one emit step per chunk; a final word also passes
// through a clear step after its chunks. An emit step holds in place while the
// output is stalled. The longest case without stalls is a final word at width 1
// that makes 32 chunks. The next item is accepted only when the sequencer is
// back at its wait step; the final chunk may still sit in the output register then.
// Writing chunk_width (address 0) also empties the residue, so write it only
// between strings while the block is idle.
module word_stream_bit_chunker_unit #(
    parameter int MAX_CHUNK_WIDTH = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input items
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [wsbc_pkg::WORD_W-1:0] data_word,
    input  logic                        final_word,
    // result items
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [MAX_CHUNK_WIDTH-1:0]  chunk_value,
    output logic                        run_end,
    output logic                        string_end
);
    import wsbc_pkg::*;

    logic [CFG_W-1:0] chunk_width_reg;
    logic [CFG_W-1:0] chunk_width_next;
    logic             cfg_wr;
    logic             reg_sel;
    wsbc_ctrl_t       ctrl;
    wsbc_stat_t       stat;

    // register index is the word address; only index 0 exists
    assign reg_sel = (paddr[2] == REG_CHUNK_WIDTH);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    assign chunk_width_next = cfg_wr ? pwdata[CFG_W-1:0] : chunk_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_width_reg <= CHUNK_WIDTH_RST;
        end
        else
        begin
            chunk_width_reg <= chunk_width_next;
        end
    end

    assign prdata = reg_sel ? 32'(chunk_width_reg) : 32'd0;

    wsbc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    wsbc_datapath #(
        .MAX_CHUNK_WIDTH (MAX_CHUNK_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_width (chunk_width_reg),
        .cfg_clear   (cfg_wr),
        .data_word   (data_word),
        .final_word  (final_word),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .chunk_value (chunk_value),
        .run_end     (run_end),
        .string_end  (string_end)
    );

endmodule
